// ===== design/assert_macros.svh =====
// assertion macros for the design files, included by bve_seq
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked at every edge outside reset
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent checked at the edge after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_CHK(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/bve_pkg.sv =====
// types and constants of the bounded vector engine
package bve_pkg;

  localparam int DEPTH  = 256;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam int ACT_W     = 3;
  localparam int IDX_W     = 8;
  localparam int VAL_W     = 32;
  localparam int FOUND_W   = 8;
  localparam int ECOUNT_W  = 9;
  localparam int WORD_W    = 32;

  localparam int IN_TDATA_W  = ((IDX_W + VAL_W + 7) / 8) * 8;
  localparam int OUT_BITS_W  = WORD_W + FOUND_W + ECOUNT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 3'd0,
    ACT_READ   = 3'd1,
    ACT_WRITE  = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_ZERO   = 3'd4,
    ACT_EMPTY  = 3'd5,
    ACT_FIND   = 3'd6
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WALK = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  typedef struct packed {
    logic                ok;
    logic [WORD_W-1:0]   read_data;
    logic [FOUND_W-1:0]  found_index;
    logic [ECOUNT_W-1:0] entry_count;
  } res_t;

endpackage

// ===== design/bve_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module bve_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/bve_seq.sv =====
// request sequencer: decodes actions and walks the entry memory
`include "assert_macros.svh"

module bve_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bve_pkg::action_t           in_action,
  input  logic [bve_pkg::IDX_W-1:0]  in_index,
  input  logic [bve_pkg::VAL_W-1:0]  in_value,
  output logic                       res_valid,
  input  logic                       res_ready,
  output bve_pkg::res_t              res,
  output logic                       mem_we,
  output logic [bve_pkg::ADDR_W-1:0] mem_waddr,
  output logic [bve_pkg::WORD_W-1:0] mem_wdata,
  output logic                       mem_re,
  output logic [bve_pkg::ADDR_W-1:0] mem_raddr,
  input  logic [bve_pkg::WORD_W-1:0] mem_rdata
);
  import bve_pkg::*;

  state_t              state_r, state_nxt;
  action_t             act_r, act_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [VAL_W-1:0]    val_r, val_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    ptr_r, ptr_nxt;
  logic [CNT_W-1:0]    end_r, end_nxt;
  logic                pend_r, pend_nxt;
  logic [ADDR_W-1:0]   pend_addr_r, pend_addr_nxt;
  logic                ok_r, ok_nxt;
  logic [WORD_W-1:0]   rd_r, rd_nxt;
  logic [FOUND_W-1:0]  found_r, found_nxt;

  logic [CNT_W-1:0]    idx_ext;
  logic                in_range;
  logic                more;
  logic                wr_legal;

  assign idx_ext  = CNT_W'(idx_r);
  assign in_range = idx_ext < count_r;
  assign more     = ptr_r < end_r;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = '{ok: ok_r, read_data: rd_r, found_index: found_r,
                       entry_count: ECOUNT_W'(count_r)};

  // append writes just past the stored entries, everything else inside them
  assign wr_legal = (act_r == ACT_APPEND) ? (CNT_W'(mem_waddr) == count_r)
                                          : (CNT_W'(mem_waddr) < count_r);

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    end_nxt       = end_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    ok_nxt        = ok_r;
    rd_nxt        = rd_r;
    found_nxt     = found_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = ptr_r[ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt   = in_action;
          idx_nxt   = in_index;
          val_nxt   = in_value;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        ok_nxt    = 1'b0;
        rd_nxt    = '0;
        found_nxt = '0;
        pend_nxt  = 1'b0;
        state_nxt = S_DONE;
        unique case (act_r)
          ACT_APPEND: begin
            if (count_r < CNT_W'(DEPTH)) begin
              mem_we    = 1'b1;
              mem_waddr = count_r[ADDR_W-1:0];
              mem_wdata = val_r;
              count_nxt = count_r + CNT_W'(1);
              ok_nxt    = 1'b1;
            end
          end
          ACT_READ: begin
            if (in_range) begin
              ptr_nxt   = idx_ext;
              end_nxt   = idx_ext + CNT_W'(1);
              state_nxt = S_WALK;
            end
          end
          ACT_WRITE: begin
            if (in_range) begin
              mem_we    = 1'b1;
              mem_waddr = idx_ext[ADDR_W-1:0];
              mem_wdata = val_r;
              ok_nxt    = 1'b1;
            end
          end
          ACT_REMOVE: begin
            if (in_range) begin
              ptr_nxt   = idx_ext + CNT_W'(1);
              end_nxt   = count_r;
              state_nxt = S_WALK;
            end
          end
          ACT_ZERO, ACT_FIND: begin
            ptr_nxt   = '0;
            end_nxt   = count_r;
            state_nxt = S_WALK;
          end
          ACT_EMPTY: begin
            count_nxt = '0;
            ok_nxt    = 1'b1;
          end
          default: begin
          end
        endcase
      end

      S_WALK: begin
        if (act_r == ACT_ZERO) begin
          if (more) begin
            mem_we    = 1'b1;
            mem_waddr = ptr_r[ADDR_W-1:0];
            mem_wdata = '0;
            ptr_nxt   = ptr_r + CNT_W'(1);
          end else begin
            ok_nxt    = 1'b1;
            state_nxt = S_DONE;
          end
        end else begin
          // reads stream out one per cycle, data comes back in the cycle after
          if (more) begin
            mem_re        = 1'b1;
            ptr_nxt       = ptr_r + CNT_W'(1);
            pend_nxt      = 1'b1;
            pend_addr_nxt = ptr_r[ADDR_W-1:0];
          end else begin
            pend_nxt = 1'b0;
          end

          if (pend_r) begin
            if (act_r == ACT_READ) begin
              ok_nxt    = 1'b1;
              rd_nxt    = mem_rdata;
              state_nxt = S_DONE;
            end else if (act_r == ACT_REMOVE) begin
              // write trails the read by two entries, so no overlap
              mem_we    = 1'b1;
              mem_waddr = pend_addr_r - ADDR_W'(1);
              mem_wdata = mem_rdata;
            end else if (mem_rdata == val_r) begin
              ok_nxt    = 1'b1;
              found_nxt = FOUND_W'(pend_addr_r);
              state_nxt = S_DONE;
            end
          end

          if (!more && !pend_r) begin
            if (act_r == ACT_REMOVE) begin
              count_nxt = count_r - CNT_W'(1);
              ok_nxt    = 1'b1;
            end
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    idx_r       <= idx_nxt;
    val_r       <= val_nxt;
    ptr_r       <= ptr_nxt;
    end_r       <= end_nxt;
    pend_addr_r <= pend_addr_nxt;
    ok_r        <= ok_nxt;
    rd_r        <= rd_nxt;
    found_r     <= found_nxt;
  end

  `ASSERT_CHK(a_count_bound, count_r <= CNT_W'(DEPTH), "entry count above depth")
  `ASSERT_CHK(a_write_in_store, mem_we |-> wr_legal, "write outside stored entries")
  `ASSERT_CHK(a_read_in_store, mem_re |-> (CNT_W'(mem_raddr) < count_r), "read beyond entry count")
  `ASSERT_NEXT(a_exec_clears_pend, state_r == S_EXEC, !pend_r, "stale read pending at walk start")

endmodule

// ===== design/bounded_vector_engine.sv =====
// top level of the bounded vector engine
// Ordered store of up to 256 32-bit words with an element count, one request at a time.
// The entries sit in one ram with a registered read; the sequencer does
// read-modify-write through it. Append, write, empty and the unused action code
// finish without a memory walk; read walks a single entry, zero all writes one
// entry per cycle, remove and find read one entry per cycle through the ram's single
// read port, find stops at the first match. A finished result waits in the output
// register, so the next transaction is taken while it is still unclaimed. No clearing
// pass after reset.
module bounded_vector_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bve_pkg::ACT_W-1:0]         in_tuser,  // action
  input  logic [bve_pkg::IN_TDATA_W-1:0]    in_tdata,  // index, value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [0:0]                        out_tuser, // ok
  output logic [bve_pkg::OUT_TDATA_W-1:0]   out_tdata  // read_data, found_index, entry_count
);
  import bve_pkg::*;

  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [WORD_W-1:0]    mem_wdata;
  logic                 mem_re;
  logic [ADDR_W-1:0]    mem_raddr;
  logic [WORD_W-1:0]    mem_rdata;

  logic                 res_valid;
  logic                 res_ready;
  res_t                 res;

  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_res_r;

  bve_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bve_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (action_t'(in_tuser)),
    .in_index  (in_tdata[IDX_W-1:0]),
    .in_value  (in_tdata[IDX_W +: VAL_W]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // output slot frees when empty or when its transaction completes
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.ok;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_res_r.entry_count,
                       out_res_r.found_index, out_res_r.read_data};

endmodule
